// ===== hdl/rld_pkg.sv =====
// Package for the link message deframer.
// Holds the field widths, the message layout and shared constants.
// No dependencies.
`default_nettype none

package rld_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned AckW     = 2;
  localparam int unsigned OffW     = 8;
  localparam int unsigned AddrW    = 16;
  localparam int unsigned CallW    = 8;
  localparam int unsigned TypeW    = 3;
  localparam int unsigned PayFirstW = 21;
  localparam int unsigned InDataW  = 40;

  localparam logic [OffW-1:0] WindowReset = 8'd32;
  localparam logic [OffW-1:0] LastWordOff = 8'd3;

  typedef enum logic [AckW-1:0] {
    ACK_NONE    = 2'd0,
    ACK_ACCEPT  = 2'd1,
    ACK_REFUSE  = 2'd2,
    ACK_REFUSE2 = 2'd3
  } ack_t;

  // Members are listed from the highest bits down.
  typedef struct packed {
    logic [WordW-1:0]     payload_third;
    logic [WordW-1:0]     payload_second;
    logic [PayFirstW-1:0] payload_first;
    logic [TypeW-1:0]     message_type;
    logic [CallW-1:0]     call_number;
    logic [AddrW-1:0]     dest_addr;
    logic [AddrW-1:0]     source_addr;
  } msg_t;

endpackage

`default_nettype wire

// ===== hdl/rld_out_skid.sv =====
// Two-entry output stage for decoded messages: output register plus skid register.
// Depends on rld_pkg for the message type.
`default_nettype none

module rld_out_skid (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire rld_pkg::msg_t push_msg,
  output logic               room,
  output logic               out_valid,
  input  wire logic          out_ready,
  output rld_pkg::msg_t      out_msg
);
  import rld_pkg::*;

  logic out_valid_r;
  logic skid_valid_r;
  msg_t out_msg_r;
  msg_t skid_msg_r;
  logic pop;

  assign pop       = out_valid_r & out_ready;
  assign room      = ~skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_msg   = out_msg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_valid_r) begin
          out_msg_r    <= skid_msg_r;
          skid_valid_r <= push;
          if (push) begin
            skid_msg_r <= push_msg;
          end
        end else begin
          out_valid_r <= push;
          if (push) begin
            out_msg_r <= push_msg;
          end
        end
      end else if (push) begin
        if (!out_valid_r) begin
          out_valid_r <= 1'b1;
          out_msg_r   <= push_msg;
        end else begin
          skid_valid_r <= 1'b1;
          skid_msg_r   <= push_msg;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rpc_link_message_deframer.sv =====
// Link message deframer: one sample per word, at most one decoded message per word.
// A decoded message is registered in the output stage when its closing word is taken.
// Throughput: one word per cycle; input stalls only when both output entries are full.
// Reset (synchronous, active low) returns to strobe search and sets the window to 32.
// Depends on rld_pkg and rld_out_skid.
`default_nettype none

module rpc_link_message_deframer (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_wr_en,
  input  wire logic [rld_pkg::OffW-1:0]    cfg_wr_data,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  // Fields from bit 0: ack_code[1:0], link_word[33:2], zero fill to bit 39.
  input  wire logic [rld_pkg::InDataW-1:0] in_tdata,
  // Fields from bit 0: start_strobe.
  input  wire logic                        in_tuser,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  // Fields from bit 0: source_addr, dest_addr, call_number, message_type,
  // payload_first, payload_second, payload_third.
  output logic [$bits(rld_pkg::msg_t)-1:0] out_tdata
);
  import rld_pkg::*;

  logic [OffW-1:0]  ack_window_r;
  logic             in_message_r, in_message_nxt;
  logic [OffW-1:0]  cycle_offset_r, cycle_offset_nxt;
  logic [AckW-1:0]  ack_seen_r, ack_seen_nxt;
  logic [WordW-1:0] cap_r   [4];
  logic [WordW-1:0] cap_nxt [4];

  logic             accept;
  logic [AckW-1:0]  ack;
  logic [WordW-1:0] word;
  logic [OffW-1:0]  off;
  logic [AckW-1:0]  seen_cur;
  logic             close;
  logic             emit;
  msg_t             msg;
  msg_t             out_msg;
  logic             room;

  assign accept    = in_tvalid & in_tready;
  assign in_tready = room;
  assign ack       = in_tdata[AckW-1:0];
  assign word      = in_tdata[AckW +: WordW];
  assign off       = cycle_offset_r + 8'd1;

  always_comb begin
    in_message_nxt   = in_message_r;
    cycle_offset_nxt = cycle_offset_r;
    ack_seen_nxt     = ack_seen_r;
    for (int i = 0; i < 4; i++) begin
      cap_nxt[i] = cap_r[i];
    end
    seen_cur = ack_seen_r;
    close    = 1'b0;
    emit     = 1'b0;

    if (in_message_r) begin
      cycle_offset_nxt = off;
      if (off <= LastWordOff) begin
        cap_nxt[off[1:0]] = word;
      end
      if (ack_seen_r == ACK_NONE && off < ack_window_r && ack != ACK_NONE) begin
        seen_cur = ack;
      end
      ack_seen_nxt = seen_cur;
      close = (off >= LastWordOff) && (seen_cur != ACK_NONE || off >= ack_window_r);
      emit  = close && seen_cur == ACK_ACCEPT;
      if (close) begin
        in_message_nxt = 1'b0;
      end
    end

    if ((!in_message_r || close) && in_tuser) begin
      in_message_nxt   = 1'b1;
      cycle_offset_nxt = '0;
      cap_nxt[0]       = word;
      if (ack_window_r != '0 && ack != ACK_NONE) begin
        ack_seen_nxt = ack;
      end else begin
        ack_seen_nxt = ACK_NONE;
      end
    end
  end

  // At the last body word the third payload comes straight from the input.
  always_comb begin
    msg.source_addr    = cap_r[0][WordW-1:AddrW];
    msg.dest_addr      = cap_r[0][AddrW-1:0];
    msg.call_number    = cap_r[1][31:24];
    msg.message_type   = cap_r[1][23:21];
    msg.payload_first  = cap_r[1][PayFirstW-1:0];
    msg.payload_second = cap_r[2];
    msg.payload_third  = (off == LastWordOff) ? word : cap_r[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_window_r   <= WindowReset;
      in_message_r   <= 1'b0;
      cycle_offset_r <= '0;
      ack_seen_r     <= ACK_NONE;
    end else begin
      if (cfg_wr_en) begin
        ack_window_r <= cfg_wr_data;
      end
      if (accept) begin
        in_message_r   <= in_message_nxt;
        cycle_offset_r <= cycle_offset_nxt;
        ack_seen_r     <= ack_seen_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < 4; i++) begin
        cap_r[i] <= cap_nxt[i];
      end
    end
  end

  rld_out_skid u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept & emit),
    .push_msg  (msg),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_msg   (out_msg)
  );

  assign out_tdata = out_msg;

endmodule

`default_nettype wire
